// File: src/force_admittance_servo_control_macros.svh
// Assertion macros for the force admittance servo control block.
// Used by the port checker; expects clk and rst_n in the calling scope.
`ifndef FORCE_ADMITTANCE_SERVO_CONTROL_MACROS_SVH
`define FORCE_ADMITTANCE_SERVO_CONTROL_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FASC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FASC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fasc_pkg.sv
// Shared types and constants for the force admittance servo control block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fasc_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_SENSOR = 2'd0,
        KIND_SERVO  = 2'd1,
        KIND_TARE   = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ASYM_GAIN      = 3'd0,
        CFG_DEAD_ZONE      = 3'd1,
        CFG_WALL_FORCE     = 3'd2,
        CFG_SPEED_SCALE    = 3'd3,
        CFG_MAX_SPEED      = 3'd4,
        CFG_ONLY_RESISTIVE = 3'd5,
        CFG_FILTER_ENABLE  = 3'd6
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration reset values
    localparam logic [9:0]  ASYM_GAIN_RST   = 10'd448;
    localparam logic [15:0] DEAD_ZONE_RST   = 16'd320;
    localparam logic [15:0] WALL_FORCE_RST  = 16'd3200;
    localparam logic [9:0]  SPEED_SCALE_RST = 10'd51;
    localparam logic [15:0] MAX_SPEED_RST   = 16'd12800;

    // Angles and pulse mapping
    localparam logic [15:0] ANGLE_MAX_Q8   = 16'd46080;
    localparam logic [15:0] ANGLE_START_Q8 = 16'd23040;
    localparam logic [9:0]  POT_FULL       = 10'd1023;
    localparam logic [11:0] PULSE_MIN      = 12'd500;
    localparam logic [11:0] PULSE_MAX      = 12'd2500;
    localparam logic [11:0] PULSE_START    = 12'd1500;
    // round up of 2^24 * 2000 / 46080; exact after >> 24 over the angle range
    localparam logic [23:0] PULSE_RECIP    = 24'd728178;

    // 21-bit force saturation limits
    localparam logic signed [20:0] F21_MAX = 21'sh0FFFFF;
    localparam logic signed [20:0] F21_MIN = 21'sh100000;

    // Shared multiplier: signed A by unsigned B
    localparam int MUL_A_W = 23;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Step division: |speed| * elapsed over one million microseconds.
    // Top 22 dividend bits times floor(2^42 / 10^6), taken >> 24, never
    // overshoots and is at most one short; a single remainder compare fixes it.
    localparam int DIVIDEND_W = 40;
    localparam int QUOT_W     = 21;
    localparam int DIV_HI_LSB = 18;
    localparam int EST_SHIFT  = 24;
    localparam int EST_W      = EST_SHIFT + QUOT_W;
    localparam logic [MUL_B_W-1:0] STEP_DIV   = 24'd1000000;
    localparam logic [MUL_B_W-1:0] STEP_RECIP = 24'd4398046;

endpackage

// File: src/fasc_mul.sv
// Shared registered multiplier: signed operand times unsigned operand.
// Depends on fasc_pkg for operand and product widths.
`timescale 1ns / 1ps

module fasc_mul
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [fasc_pkg::MUL_A_W-1:0]   a,
    input  logic        [fasc_pkg::MUL_B_W-1:0]   b,
    output logic signed [fasc_pkg::MUL_P_W-1:0]   p
);

    logic signed [fasc_pkg::MUL_P_W:0]   prod;
    logic signed [fasc_pkg::MUL_P_W-1:0] p_reg;

    // B is zero extended so the product stays signed
    assign prod = a * $signed({1'b0, b});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= prod[fasc_pkg::MUL_P_W-1:0];
        end
    end

    assign p = p_reg;

endmodule

// File: src/fasc_div.sv
// Division of the step product by one million from a reciprocal estimate and one fix-up.
// Works on products of the shared multiplier; depends on fasc_pkg for widths and constants.
`timescale 1ns / 1ps

module fasc_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 est_load,
    input  logic                                 fix,
    input  logic [fasc_pkg::EST_W-1:0]           prod,
    output logic [fasc_pkg::QUOT_W-1:0]          quotient
);

    logic [fasc_pkg::DIVIDEND_W-1:0] dividend_reg;
    logic [fasc_pkg::QUOT_W-1:0]     quot_reg;

    logic [fasc_pkg::DIVIDEND_W-1:0] rem;
    logic                            ge;

    // prod holds estimate * 10^6 here; the remainder is below two divisors
    assign rem = dividend_reg - prod[fasc_pkg::DIVIDEND_W-1:0];
    assign ge  = rem >= fasc_pkg::DIVIDEND_W'(fasc_pkg::STEP_DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dividend_reg <= '0;
            quot_reg     <= '0;
        end
        else if (load)
        begin
            dividend_reg <= prod[fasc_pkg::DIVIDEND_W-1:0];
        end
        else if (est_load)
        begin
            quot_reg <= prod[fasc_pkg::EST_SHIFT +: fasc_pkg::QUOT_W];
        end
        else if (fix)
        begin
            quot_reg <= quot_reg + fasc_pkg::QUOT_W'(ge);
        end
    end

    assign quotient = quot_reg;

endmodule

// File: src/force_admittance_servo_control.sv
// Force admittance servo control, top level: sequencer, state and config registers.
// Tare and no-op items go straight to emit; a sensor item runs gain, filter and dead zone;
// a servo tick runs wall, speed, clamp, step, divide, angle and pulse steps, with five
// passes through the shared multiplier. One item at a time; in_ready rises with the result.
// A held result lets the next item in, which then waits in its last step for out_ready.
// Asynchronous active-low reset restores config defaults, 90 degree joint angle.
`timescale 1ns / 1ps

module force_admittance_servo_control
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_write,
    input  logic [fasc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fasc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            kind,
    input  logic signed [19:0]                    force_sample_q4,
    input  logic [9:0]                            pot_reading,
    input  logic [23:0]                           elapsed_us,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [11:0]                           pulse_us,
    output logic [15:0]                           joint_angle_q8,
    output logic signed [20:0]                    adjusted_force_q4,
    output logic                                  held_at_wall
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN,
        S_FILT,
        S_DZ,
        S_WALL,
        S_SPEED,
        S_CLAMP,
        S_STEP,
        S_RECIP,
        S_BACK,
        S_FIX,
        S_ANGLE,
        S_PULSE,
        S_PULSE_WB,
        S_EMIT
    } state_t;

    // configuration
    logic [9:0]  gain_reg;
    logic [15:0] dz_reg;
    logic [15:0] wf_reg;
    logic [9:0]  scale_reg;
    logic [15:0] maxs_reg;
    logic        res_reg;
    logic        filt_en_reg;

    state_t state_reg, state_next;

    // latched input fields
    logic signed [19:0] force_reg, force_next;
    logic [9:0]         pot_reg, pot_next;
    logic [23:0]        elapsed_reg, elapsed_next;

    // block state
    logic [15:0]        joint_reg, joint_next;
    logic [15:0]        wall_reg, wall_next;
    logic signed [20:0] adj_reg, adj_next;
    logic signed [20:0] x1_reg, x1_next;
    logic signed [20:0] y1_reg, y1_next;
    logic               held_reg, held_next;
    logic [11:0]        pulse_reg, pulse_next;

    // working registers
    logic signed [21:0] acc_reg, acc_next;
    logic               lim_reg, lim_next;
    logic signed [16:0] speed_reg, speed_next;
    logic               neg_reg, neg_next;

    // output stage
    logic               out_valid_reg, out_valid_next;
    logic [11:0]        out_pulse_reg, out_pulse_next;
    logic [15:0]        out_joint_reg, out_joint_next;
    logic signed [20:0] out_force_reg, out_force_next;
    logic               out_held_reg, out_held_next;

    // shared units
    logic                                  mul_en;
    logic signed [fasc_pkg::MUL_A_W-1:0]   mul_a;
    logic        [fasc_pkg::MUL_B_W-1:0]   mul_b;
    logic signed [fasc_pkg::MUL_P_W-1:0]   mul_p;
    logic                                  div_load;
    logic                                  div_est;
    logic                                  div_fix;
    logic [fasc_pkg::QUOT_W-1:0]           div_q;

    // datapath intermediates
    logic               force_pos;
    logic signed [20:0] g_val;
    logic signed [22:0] fsum;
    logic signed [20:0] fy;
    logic signed [21:0] f_ext;
    logic [20:0]        f_abs;
    logic signed [21:0] f_dz;
    logic [15:0]        x45;
    logic [5:0]         q0;
    logic [10:0]        r0;
    logic [15:0]        wall_calc;
    logic               adj_pos;
    logic               apply_wall;
    logic signed [21:0] ctl_ext;
    logic signed [21:0] ctl_sub;
    logic signed [21:0] ctl_wall;
    logic signed [31:0] sp_raw;
    logic signed [31:0] sp_div;
    logic signed [31:0] max_ext;
    logic signed [16:0] max_s17;
    logic signed [16:0] speed_neg;
    logic signed [22:0] q_ext;
    logic signed [22:0] step_val;
    logic signed [23:0] ang;
    logic [15:0]        lo_lim;
    logic [15:0]        ang_c;

    fasc_mul u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    fasc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .est_load (div_est),
        .fix      (div_fix),
        .prod     (mul_p[fasc_pkg::EST_W-1:0]),
        .quotient (div_q)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= fasc_pkg::ASYM_GAIN_RST;
            dz_reg      <= fasc_pkg::DEAD_ZONE_RST;
            wf_reg      <= fasc_pkg::WALL_FORCE_RST;
            scale_reg   <= fasc_pkg::SPEED_SCALE_RST;
            maxs_reg    <= fasc_pkg::MAX_SPEED_RST;
            res_reg     <= 1'b0;
            filt_en_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (fasc_pkg::cfg_index_t'(cfg_index))
                fasc_pkg::CFG_ASYM_GAIN:      gain_reg    <= cfg_wdata[9:0];
                fasc_pkg::CFG_DEAD_ZONE:      dz_reg      <= cfg_wdata;
                fasc_pkg::CFG_WALL_FORCE:     wf_reg      <= cfg_wdata;
                fasc_pkg::CFG_SPEED_SCALE:    scale_reg   <= cfg_wdata[9:0];
                fasc_pkg::CFG_MAX_SPEED:      maxs_reg    <= cfg_wdata;
                fasc_pkg::CFG_ONLY_RESISTIVE: res_reg     <= cfg_wdata[0];
                fasc_pkg::CFG_FILTER_ENABLE:  filt_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Gain and filter
    always_comb
    begin
        force_pos = !force_reg[19] && (|force_reg);
        if (!force_pos)
            g_val = {force_reg[19], force_reg};
        else if (|mul_p[fasc_pkg::MUL_P_W-1:28])
            g_val = fasc_pkg::F21_MAX;
        else
            g_val = {1'b0, mul_p[27:8]};

        fsum = {{2{g_val[20]}}, g_val} + {{2{x1_reg[20]}}, x1_reg}
             - {{2{y1_reg[20]}}, y1_reg};
        if (fsum > 23'sd1048575)
            fy = fasc_pkg::F21_MAX;
        else if (fsum < -23'sd1048576)
            fy = fasc_pkg::F21_MIN;
        else
            fy = fsum[20:0];
    end

    // Dead zone and wall angle
    always_comb
    begin
        f_ext = {acc_reg[20], acc_reg[20:0]};
        f_abs = acc_reg[20] ? 21'(-f_ext) : acc_reg[20:0];
        if (f_abs < {5'b0, dz_reg})
            f_dz = '0;
        else if (acc_reg[20])
            f_dz = f_ext + $signed({6'b0, dz_reg});
        else
            f_dz = f_ext - $signed({6'b0, dz_reg});

        // pot * 46080 / 1023 = 45 * pot + (45 * pot) / 1023
        x45 = {1'b0, pot_reg, 5'b0} + {3'b0, pot_reg, 3'b0}
            + {4'b0, pot_reg, 2'b0} + {6'b0, pot_reg};
        q0  = x45[15:10];
        r0  = {1'b0, x45[9:0]} + {5'b0, q0};
        wall_calc = x45 + {10'b0, q0} + {15'b0, (r0 >= {1'b0, fasc_pkg::POT_FULL})};
    end

    // Wall rule, speed clamp and angle integration
    always_comb
    begin
        adj_pos    = !adj_reg[20] && (|adj_reg);
        apply_wall = (joint_reg >= wall_reg) && (!res_reg || adj_pos);
        ctl_ext    = {adj_reg[20], adj_reg};
        ctl_sub    = ctl_ext - $signed({6'b0, wf_reg});
        ctl_wall   = (res_reg && ctl_sub[21]) ? 22'sd0 : ctl_sub;

        // divide by 16 rounding toward zero
        sp_raw  = mul_p[31:0];
        sp_div  = (sp_raw + (sp_raw[31] ? 32'sd15 : 32'sd0)) >>> 4;
        max_ext = $signed({16'b0, maxs_reg});
        max_s17 = $signed({1'b0, maxs_reg});
        speed_neg = -speed_reg;

        q_ext    = $signed({2'b0, div_q});
        step_val = neg_reg ? -q_ext : q_ext;
        ang      = $signed({8'b0, joint_reg}) + {step_val[22], step_val};
        lo_lim   = lim_reg ? wall_reg : 16'd0;
        if (ang > $signed({8'b0, fasc_pkg::ANGLE_MAX_Q8}))
            ang_c = fasc_pkg::ANGLE_MAX_Q8;
        else if (ang < $signed({8'b0, lo_lim}))
            ang_c = lo_lim;
        else
            ang_c = ang[15:0];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        force_next     = force_reg;
        pot_next       = pot_reg;
        elapsed_next   = elapsed_reg;
        joint_next     = joint_reg;
        wall_next      = wall_reg;
        adj_next       = adj_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        held_next      = held_reg;
        pulse_next     = pulse_reg;
        acc_next       = acc_reg;
        lim_next       = lim_reg;
        speed_next     = speed_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_pulse_next = out_pulse_reg;
        out_joint_next = out_joint_reg;
        out_force_next = out_force_reg;
        out_held_next  = out_held_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_load       = 1'b0;
        div_est        = 1'b0;
        div_fix        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    force_next   = force_sample_q4;
                    pot_next     = pot_reading;
                    elapsed_next = elapsed_us;
                    case (fasc_pkg::kind_t'(kind))
                        fasc_pkg::KIND_SENSOR: state_next = S_GAIN;
                        fasc_pkg::KIND_SERVO:  state_next = S_WALL;
                        fasc_pkg::KIND_TARE:
                        begin
                            x1_next    = '0;
                            y1_next    = '0;
                            state_next = S_EMIT;
                        end
                        default: state_next = S_EMIT;
                    endcase
                end
            end
            S_GAIN:
            begin
                mul_en     = 1'b1;
                mul_a      = {{3{force_reg[19]}}, force_reg};
                mul_b      = {14'b0, gain_reg};
                state_next = S_FILT;
            end
            S_FILT:
            begin
                if (filt_en_reg)
                begin
                    x1_next  = g_val;
                    y1_next  = fy;
                    acc_next = {fy[20], fy};
                end
                else
                begin
                    acc_next = {g_val[20], g_val};
                end
                state_next = S_DZ;
            end
            S_DZ:
            begin
                adj_next   = f_dz[20:0];
                wall_next  = wall_calc;
                state_next = S_EMIT;
            end
            S_WALL:
            begin
                acc_next   = apply_wall ? ctl_wall : ctl_ext;
                lim_next   = apply_wall && !adj_reg[20];
                state_next = S_SPEED;
            end
            S_SPEED:
            begin
                mul_en     = 1'b1;
                mul_a      = {acc_reg[21], acc_reg};
                mul_b      = {14'b0, scale_reg};
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (sp_div > max_ext)
                    speed_next = max_s17;
                else if (sp_div < -max_ext)
                    speed_next = -max_s17;
                else
                    speed_next = sp_div[16:0];
                state_next = S_STEP;
            end
            S_STEP:
            begin
                mul_en     = 1'b1;
                mul_a      = {7'b0, (speed_reg[16] ? speed_neg[15:0] : speed_reg[15:0])};
                mul_b      = elapsed_reg;
                neg_next   = speed_reg[16];
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                // keep the dividend, estimate the quotient from its top bits
                div_load   = 1'b1;
                mul_en     = 1'b1;
                mul_a      = {1'b0, mul_p[fasc_pkg::DIVIDEND_W-1:fasc_pkg::DIV_HI_LSB]};
                mul_b      = fasc_pkg::STEP_RECIP;
                state_next = S_BACK;
            end
            S_BACK:
            begin
                div_est    = 1'b1;
                mul_en     = 1'b1;
                mul_a      = {2'b0, mul_p[fasc_pkg::EST_SHIFT +: fasc_pkg::QUOT_W]};
                mul_b      = fasc_pkg::STEP_DIV;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                div_fix    = 1'b1;
                state_next = S_ANGLE;
            end
            S_ANGLE:
            begin
                joint_next = ang_c;
                held_next  = lim_reg;
                state_next = S_PULSE;
            end
            S_PULSE:
            begin
                mul_en     = 1'b1;
                mul_a      = {7'b0, joint_reg};
                mul_b      = fasc_pkg::PULSE_RECIP;
                state_next = S_PULSE_WB;
            end
            S_PULSE_WB:
            begin
                pulse_next = fasc_pkg::PULSE_MIN + {1'b0, mul_p[34:24]};
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pulse_next = pulse_reg;
                    out_joint_next = joint_reg;
                    out_force_next = adj_reg;
                    out_held_next  = held_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            force_reg     <= '0;
            pot_reg       <= '0;
            elapsed_reg   <= '0;
            joint_reg     <= fasc_pkg::ANGLE_START_Q8;
            wall_reg      <= '0;
            adj_reg       <= '0;
            x1_reg        <= '0;
            y1_reg        <= '0;
            held_reg      <= 1'b0;
            pulse_reg     <= fasc_pkg::PULSE_START;
            acc_reg       <= '0;
            lim_reg       <= 1'b0;
            speed_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pulse_reg <= fasc_pkg::PULSE_START;
            out_joint_reg <= fasc_pkg::ANGLE_START_Q8;
            out_force_reg <= '0;
            out_held_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            force_reg     <= force_next;
            pot_reg       <= pot_next;
            elapsed_reg   <= elapsed_next;
            joint_reg     <= joint_next;
            wall_reg      <= wall_next;
            adj_reg       <= adj_next;
            x1_reg        <= x1_next;
            y1_reg        <= y1_next;
            held_reg      <= held_next;
            pulse_reg     <= pulse_next;
            acc_reg       <= acc_next;
            lim_reg       <= lim_next;
            speed_reg     <= speed_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            out_pulse_reg <= out_pulse_next;
            out_joint_reg <= out_joint_next;
            out_force_reg <= out_force_next;
            out_held_reg  <= out_held_next;
        end
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign pulse_us          = out_pulse_reg;
    assign joint_angle_q8    = out_joint_reg;
    assign adjusted_force_q4 = out_force_reg;
    assign held_at_wall      = out_held_reg;

endmodule

// File: src/fasc_checker.sv
// Port-level checker for the force admittance servo control block, bound to the top.
// Depends on fasc_pkg and the block's assertion macro header.
`timescale 1ns / 1ps
`include "force_admittance_servo_control_macros.svh"

module fasc_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_write,
    input logic [fasc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input logic [fasc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [1:0]                         kind,
    input logic signed [19:0]                 force_sample_q4,
    input logic [9:0]                         pot_reading,
    input logic [23:0]                        elapsed_us,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [11:0]                        pulse_us,
    input logic [15:0]                        joint_angle_q8,
    input logic signed [20:0]                 adjusted_force_q4,
    input logic                               held_at_wall
);

    // a stalled result holds its payload
    `FASC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pulse_us) && $stable(joint_angle_q8) && $stable(adjusted_force_q4) && $stable(held_at_wall), "result changed while stalled")

    // every item passes through at least one more state, so the block is busy after a transfer
    `FASC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken on consecutive cycles")

    // pulse width and angle stay within the servo range
    `FASC_ASSERT_NOW(a_out_range, out_valid, pulse_us >= fasc_pkg::PULSE_MIN && pulse_us <= fasc_pkg::PULSE_MAX && joint_angle_q8 <= fasc_pkg::ANGLE_MAX_Q8, "result out of servo range")

endmodule

bind force_admittance_servo_control fasc_checker u_fasc_checker (.*);

// File: tb/fasc_servo_checker.sv
// Result checker for force_admittance_servo_control: keeps its own copy of the loop
// state and settings, predicts the status after every input transfer, compares outputs.
// Depends on fasc_pkg for item kinds, register indexes and fixed constants.
`timescale 1ns / 1ps

module fasc_servo_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [fasc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fasc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [1:0]                            kind,
    input  logic signed [19:0]                    force_sample_q4,
    input  logic [9:0]                            pot_reading,
    input  logic [23:0]                           elapsed_us,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [11:0]                           pulse_us,
    input  logic [15:0]                           joint_angle_q8,
    input  logic signed [20:0]                    adjusted_force_q4,
    input  logic                                  held_at_wall,
    output int                                    mismatch_count,
    output int                                    status_due
);

    import fasc_pkg::*;

    typedef struct packed {
        logic [11:0]        pulse;
        logic [15:0]        angle;
        logic signed [20:0] force_q4;
        logic               held;
    } loop_status_t;

    loop_status_t status_due_q[$];

    // settings copy
    logic [9:0]  gain_q8;
    logic [15:0] dead_zone;
    logic [15:0] wall_force;
    logic [9:0]  speed_scale;
    logic [15:0] speed_limit;
    logic        resistive;
    logic        filter_on;

    // loop state
    longint joint_q8;
    longint wall_q8;
    longint force_q4;
    longint filt_x1;
    longint filt_y1;
    logic   held;

    function automatic longint clamp21(input longint v);
        if (v > longint'(F21_MAX))
            return longint'(F21_MAX);
        if (v < longint'(F21_MIN))
            return longint'(F21_MIN);
        return v;
    endfunction

    task automatic restore_reset();
        gain_q8     = ASYM_GAIN_RST;
        dead_zone   = DEAD_ZONE_RST;
        wall_force  = WALL_FORCE_RST;
        speed_scale = SPEED_SCALE_RST;
        speed_limit = MAX_SPEED_RST;
        resistive   = 1'b0;
        filter_on   = 1'b0;
        joint_q8    = longint'(ANGLE_START_Q8);
        wall_q8     = 0;
        force_q4    = 0;
        filt_x1     = 0;
        filt_y1     = 0;
        held        = 1'b0;
    endtask

    task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ASYM_GAIN:      gain_q8     = data[9:0];
            CFG_DEAD_ZONE:      dead_zone   = data;
            CFG_WALL_FORCE:     wall_force  = data;
            CFG_SPEED_SCALE:    speed_scale = data[9:0];
            CFG_MAX_SPEED:      speed_limit = data;
            CFG_ONLY_RESISTIVE: resistive   = data[0];
            CFG_FILTER_ENABLE:  filter_on   = data[0];
            default: ;
        endcase
    endtask

    // One step of the servo loop; returns the status reported after the item.
    function automatic loop_status_t advance_servo_loop(input logic [1:0] k,
                                                        input logic signed [19:0] raw_force,
                                                        input logic [9:0] pot,
                                                        input logic [23:0] elapsed);
        longint f;
        longint y;
        longint ctl;
        longint speed;
        longint step;
        longint ang;
        longint floor_q8;
        longint dz;
        longint g;
        longint wf;
        longint sc;
        longint vmax;
        logic   at_wall;
        loop_status_t s;
        // widen every setting first so no product goes unsigned
        dz   = longint'(dead_zone);
        g    = longint'(gain_q8);
        wf   = longint'(wall_force);
        sc   = longint'(speed_scale);
        vmax = longint'(speed_limit);
        case (k)
            KIND_SENSOR:
            begin
                f = raw_force;
                if (f > 0)
                    f = clamp21((f * g) / 256);
                if (filter_on)
                begin
                    y = clamp21(f + filt_x1 - filt_y1);
                    filt_x1 = f;
                    filt_y1 = y;
                    f = y;
                end
                if ((f < 0 ? -f : f) < dz)
                    f = 0;
                else if (f > 0)
                    f = f - dz;
                else
                    f = f + dz;
                force_q4 = clamp21(f);
                wall_q8 = (longint'(pot) * longint'(ANGLE_MAX_Q8)) / longint'(POT_FULL);
            end
            KIND_SERVO:
            begin
                ctl = force_q4;
                at_wall = 1'b0;
                if (joint_q8 >= wall_q8 && (!resistive || ctl > 0))
                begin
                    // hold only counts when the operator was not already pulling back
                    at_wall = (ctl >= 0);
                    ctl = ctl - wf;
                    if (resistive && ctl < 0)
                        ctl = 0;
                end
                speed = (ctl * sc) / 16;
                if (speed > vmax)
                    speed = vmax;
                if (speed < -vmax)
                    speed = -vmax;
                step = (speed * longint'(elapsed)) / longint'(STEP_DIV);
                floor_q8 = at_wall ? wall_q8 : 0;
                ang = joint_q8 + step;
                if (ang > longint'(ANGLE_MAX_Q8))
                    ang = longint'(ANGLE_MAX_Q8);
                if (ang < floor_q8)
                    ang = floor_q8;
                joint_q8 = ang;
                held = at_wall;
            end
            KIND_TARE:
            begin
                filt_x1 = 0;
                filt_y1 = 0;
            end
            default: ;
        endcase
        s.pulse = 12'(longint'(PULSE_MIN)
                      + (joint_q8 * longint'(PULSE_MAX - PULSE_MIN)) / longint'(ANGLE_MAX_Q8));
        s.angle = 16'(joint_q8);
        s.force_q4 = 21'(force_q4);
        s.held = held;
        return s;
    endfunction

    task automatic check_status();
        loop_status_t want;
        if (status_due_q.size() == 0)
        begin
            $error("result with nothing expected: pulse_us %0d joint_angle_q8 %0d",
                   pulse_us, joint_angle_q8);
            mismatch_count++;
            return;
        end
        want = status_due_q.pop_front();
        if (pulse_us !== want.pulse)
        begin
            $error("pulse_us: expected %0d, got %0d", want.pulse, pulse_us);
            mismatch_count++;
        end
        if (joint_angle_q8 !== want.angle)
        begin
            $error("joint_angle_q8: expected %0d, got %0d", want.angle, joint_angle_q8);
            mismatch_count++;
        end
        if (adjusted_force_q4 !== want.force_q4)
        begin
            $error("adjusted_force_q4: expected %0d, got %0d", want.force_q4,
                   adjusted_force_q4);
            mismatch_count++;
        end
        if (held_at_wall !== want.held)
        begin
            $error("held_at_wall: expected %0d, got %0d", want.held, held_at_wall);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_reset();
            status_due_q.delete();
        end
        else
        begin
            if (cfg_write)
                apply_register(cfg_index, cfg_wdata);
            if (in_valid && in_ready)
                status_due_q.push_back(advance_servo_loop(kind, force_sample_q4,
                                                          pot_reading, elapsed_us));
            if (out_valid && out_ready)
                check_status();
        end
        status_due = status_due_q.size();
    end

endmodule

// File: tb/tb.sv
// Testbench top for force_admittance_servo_control: clock, reset, stimulus and verdict.
// Depends on fasc_pkg, the block itself and fasc_servo_checker for prediction.
`timescale 1ns / 1ps

module tb;

    import fasc_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 40;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             kind;
    logic signed [19:0]     force_sample_q4;
    logic [9:0]             pot_reading;
    logic [23:0]            elapsed_us;
    logic                   out_valid;
    logic                   out_ready;
    logic [11:0]            pulse_us;
    logic [15:0]            joint_angle_q8;
    logic signed [20:0]     adjusted_force_q4;
    logic                   held_at_wall;
    int                     mismatch_count;
    int                     status_due;
    int                     cycle_count = 0;
    logic                   quiet_mode = 1'b0;
    logic                   hold_off_req = 1'b0;
    logic                   hold_off_done = 1'b0;

    force_admittance_servo_control uut (.*);

    fasc_servo_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int stall_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    endfunction

    // result side: random back-pressure plus one long hold-off to fill the block
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else if (quiet_mode || $urandom_range(0, 3) != 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (stall_len() - 1) @(negedge clk);
            end
        end
    end

    // Offers one item and returns at the falling edge after its transfer.
    task automatic send_item(input kind_t k, input logic signed [19:0] f,
                             input logic [9:0] pot, input logic [23:0] el);
        if (!quiet_mode && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat (stall_len()) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        force_sample_q4 <= f;
        pot_reading <= pot;
        elapsed_us <= el;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        kind_t              k;
        int                 mag;
        logic signed [19:0] f;
        logic [23:0]        el;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = KIND_SENSOR;
            4, 5, 6, 7: k = KIND_SERVO;
            8:          k = KIND_TARE;
            default:    k = KIND_NOP;
        endcase
        mag = $urandom_range(0, 40000);
        case ($urandom_range(0, 5))
            0, 1:    f = 20'($urandom);
            2:       f = $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
            default: f = $urandom_range(0, 1) ? 20'(mag) : 20'(-mag);
        endcase
        case ($urandom_range(0, 7))
            0:       el = '0;
            1:       el = 24'($urandom);
            default: el = 24'($urandom_range(1000, 60000));
        endcase
        send_item(k, f, 10'($urandom), el);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [9:0] gain, input logic [15:0] dz,
                                 input logic [15:0] wf, input logic [9:0] scale,
                                 input logic [15:0] vmax, input logic res,
                                 input logic filt);
        write_reg(CFG_ASYM_GAIN, 16'(gain));
        write_reg(CFG_DEAD_ZONE, dz);
        write_reg(CFG_WALL_FORCE, wf);
        write_reg(CFG_SPEED_SCALE, 16'(scale));
        write_reg(CFG_MAX_SPEED, vmax);
        write_reg(CFG_ONLY_RESISTIVE, 16'(res));
        write_reg(CFG_FILTER_ENABLE, 16'(filt));
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // settings only change once every result is out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (status_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        kind = KIND_NOP;
        force_sample_q4 = '0;
        pot_reading = '0;
        elapsed_us = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: extremes, dead zone edges, wall approach
        send_item(KIND_NOP, 20'sh5A5A5, 10'h2AA, 24'hA5A5A5);
        send_item(KIND_SENSOR, 0, 0, 0);
        send_item(KIND_SERVO, 0, 0, 0);
        send_item(KIND_SENSOR, 20'sh7FFFF, 10'd1023, 0);
        send_item(KIND_SERVO, 0, 0, 24'hFFFFFF);
        send_item(KIND_SERVO, 0, 0, 20000);
        send_item(KIND_SENSOR, 20'sh80000, 0, 0);
        send_item(KIND_SERVO, 0, 0, 24'hFFFFFF);
        send_item(KIND_SENSOR, -321, 512, 0);
        send_item(KIND_SENSOR, -320, 512, 0);
        send_item(KIND_SENSOR, -319, 512, 0);
        send_item(KIND_SENSOR, 183, 512, 0);
        send_item(KIND_SENSOR, 184, 512, 0);
        send_item(KIND_SENSOR, 1, 512, 0);
        send_item(KIND_SENSOR, -1, 512, 0);
        send_item(KIND_SENSOR, 20000, 512, 0);
        send_item(KIND_SERVO, 0, 0, 25000);
        send_item(KIND_SERVO, 0, 0, 1000000);
        send_item(KIND_SERVO, 0, 0, 1000000);
        send_item(KIND_TARE, 0, 0, 0);

        // resistive wall and filter history
        wait_idle();
        load_settings(448, 320, 3200, 51, 12800, 1'b1, 1'b1);
        send_item(KIND_SENSOR, 5000, 0, 0);
        send_item(KIND_SERVO, 0, 0, 20000);
        send_item(KIND_SENSOR, -5000, 0, 0);
        send_item(KIND_SERVO, 0, 0, 20000);
        send_item(KIND_TARE, 0, 0, 0);
        send_item(KIND_SENSOR, 5000, 0, 0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                1: load_settings(10'h3FF, 16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF, 1'b1, 1'b1);
                2: load_settings(0, 0, 0, 0, 0, 1'b0, 1'b0);
                default:
                    load_settings(10'($urandom), 16'($urandom_range(0, 2000)),
                                  16'($urandom_range(0, 20000)), 10'($urandom),
                                  16'($urandom), 1'($urandom), 1'($urandom));
            endcase
            quiet_mode = (phase == 3);
            hold_off_req = (phase == 0);
            repeat (ITEMS_PER_PHASE) send_random();
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && status_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
